// ===== design/lroe_pkg.sv =====
// ----------------------------------------------------------------------------
// lroe_pkg
// Shared types, constants and arithmetic helpers for the loop recorder.
// ----------------------------------------------------------------------------
`default_nettype none

package lroe_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int MEM_DEPTH = 65536;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int NUM_BINS  = 256;
    localparam int BIN_W     = $clog2(NUM_BINS);

    localparam logic [15:0] UNITY = 16'h8000;

    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_TOGGLE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [2:0] CFG_LOOP_CAP  = 3'd0;
    localparam logic [2:0] CFG_OVERDUB   = 3'd1;
    localparam logic [2:0] CFG_DECAY     = 3'd2;
    localparam logic [2:0] CFG_FEEDBACK  = 3'd3;
    localparam logic [2:0] CFG_DECAY_CF  = 3'd4;
    localparam logic [2:0] CFG_GAIN_STEP = 3'd5;
    localparam logic [2:0] CFG_BIN_SIZE  = 3'd6;

    typedef struct packed {
        logic                rd;
        logic                ld;
        logic                m1;
        logic                m2;
        logic                m3;
        logic                wr;
        logic                clr;
        logic                first;
        logic                decay;
        logic                seed;
        logic [ADDR_W-1:0]   addr;
        logic [BIN_W-1:0]    bin;
        logic [15:0]         coef;
        logic [15:0]         fb;
        logic [15:0]         gain;
    } t_lane_ctl;

    typedef struct packed {
        logic        done;
        logic        wrote;
        logic        recording;
        logic        stop_pending;
        logic [16:0] loop_length;
        logic [15:0] write_pos;
    } t_status;

    function automatic logic [15:0] clampq(input logic [15:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    // (p + 0.5 lsb) >> 15, arithmetic
    function automatic logic signed [20:0] rnd_q15(input logic signed [35:0] p);
        logic signed [35:0] t;
        t = p + 36'sd16384;
        return t[35:15];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [22:0] v);
        if (v > 23'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -23'sd32768) begin
            return 16'sh8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/lroe_lane.sv =====
// ----------------------------------------------------------------------------
// lroe_lane
// One channel: sample memory, overdub/decay arithmetic and peak bins.
// ----------------------------------------------------------------------------
`default_nettype none

module lroe_lane (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lroe_pkg::t_lane_ctl                 i_ctl,
    input  wire logic signed [lroe_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [lroe_pkg::SAMPLE_W-1:0]      o_stored
);
    import lroe_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] r_pmin [NUM_BINS];
    logic signed [SAMPLE_W-1:0] r_pmax [NUM_BINS];
    logic [NUM_BINS-1:0]        r_pvalid;

    logic signed [SAMPLE_W-1:0] r_old;
    logic signed [SAMPLE_W-1:0] r_pmin_rd;
    logic signed [SAMPLE_W-1:0] r_pmax_rd;
    logic signed [SAMPLE_W-1:0] r_ds;
    logic signed [35:0]         r_p1;
    logic signed [35:0]         r_pfb;
    logic signed [35:0]         r_pin;
    logic signed [35:0]         r_pg;
    logic signed [SAMPLE_W-1:0] r_stored;

    logic signed [17:0]         coef_s;
    logic signed [17:0]         fb_s;
    logic signed [17:0]         gain_s;
    logic signed [16:0]         diff;
    logic signed [SAMPLE_W-1:0] n_ds;
    logic signed [SAMPLE_W-1:0] src;
    logic signed [21:0]         fb_minus_old;
    logic signed [22:0]         sum;
    logic signed [SAMPLE_W-1:0] n_new;
    logic signed [SAMPLE_W-1:0] cur_min;
    logic signed [SAMPLE_W-1:0] cur_max;
    logic signed [SAMPLE_W-1:0] n_min;
    logic signed [SAMPLE_W-1:0] n_max;

    assign coef_s = {2'b00, i_ctl.coef};
    assign fb_s   = {2'b00, i_ctl.fb};
    assign gain_s = {2'b00, i_ctl.gain};

    always_comb begin
        diff         = 17'(r_old) - 17'(r_ds);
        n_ds         = sat16(23'(r_ds) + 23'(rnd_q15(r_p1)));
        src          = i_ctl.decay ? n_ds : r_old;
        fb_minus_old = 22'(rnd_q15(r_pfb)) - 22'(r_old);
        sum          = 23'(r_old) + 23'(rnd_q15(r_pg)) + 23'(rnd_q15(r_pin));
        n_new        = i_ctl.first ? i_sample : sat16(sum);
        cur_min      = r_pvalid[i_ctl.bin] ? r_pmin_rd : '0;
        cur_max      = r_pvalid[i_ctl.bin] ? r_pmax_rd : '0;
        n_min        = (i_ctl.seed || n_new < cur_min) ? n_new : cur_min;
        n_max        = (i_ctl.seed || n_new > cur_max) ? n_new : cur_max;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_ctl.addr] <= n_new;
        end
        if (i_ctl.rd) begin
            r_old <= r_mem[i_ctl.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_pmin_rd <= r_pmin[i_ctl.bin];
            r_pmax_rd <= r_pmax[i_ctl.bin];
        end
        if (i_ctl.wr) begin
            r_pmin[i_ctl.bin] <= n_min;
            r_pmax[i_ctl.bin] <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_pvalid <= '0;
        end else if (i_ctl.wr) begin
            r_pvalid[i_ctl.bin] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds <= '0;
        end else if (i_ctl.ld) begin
            r_ds <= r_old;
        end else if (i_ctl.m2 && i_ctl.decay) begin
            r_ds <= n_ds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.m1) begin
            r_p1 <= diff * coef_s;
        end
        if (i_ctl.m2) begin
            r_pfb <= src * fb_s;
            r_pin <= i_sample * gain_s;
        end
        if (i_ctl.m3) begin
            r_pg <= fb_minus_old * gain_s;
        end
        if (i_ctl.wr) begin
            r_stored <= n_new;
        end
    end

    assign o_stored = r_stored;

endmodule

`default_nettype wire

// ===== design/lroe_ctrl.sv =====
// ----------------------------------------------------------------------------
// lroe_ctrl
// Item sequencer: record state, write index, gain ramp, bins and config.
// ----------------------------------------------------------------------------
`default_nettype none

module lroe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_kind,
    input  wire logic          i_out_free,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [16:0]   i_cfg_data,
    output lroe_pkg::t_lane_ctl o_ctl,
    output lroe_pkg::t_status  o_status
);
    import lroe_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_RD   = 9'b000000100,
        S_LD   = 9'b000001000,
        S_M1   = 9'b000010000,
        S_M2   = 9'b000100000,
        S_M3   = 9'b001000000,
        S_WR   = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state      r_state, n_state;
    logic [16:0] r_cap, r_bin_size;
    logic        r_od_en, r_decay;
    logic [15:0] r_fb, r_coef, r_step;

    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [16:0] r_frozen, n_frozen;
    logic        r_active, n_active;
    logic        r_stop, n_stop;
    logic [15:0] r_gain, n_gain;
    logic        r_last_valid, n_last_valid;
    logic [BIN_W-1:0] r_last_bin, n_last_bin;
    logic [15:0] r_bin_q, n_bin_q;
    logic [16:0] r_bin_off, n_bin_off;
    logic        r_stale, n_stale;
    logic [3:0]  r_div_cnt, n_div_cnt;
    logic        r_ld, n_ld;
    logic        r_wrote, n_wrote;

    logic        accept;
    logic        clr;
    logic        done;
    logic [15:0] step;
    logic [16:0] bs;
    logic [16:0] cap;
    logic [BIN_W-1:0] bin;
    logic        seed;
    logic [17:0] div_t;
    logic        div_ge;
    logic [16:0] idx_inc;
    logic [16:0] gain_up;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign step   = clampq(r_step);
    assign bs     = (r_bin_size == '0) ? 17'd1 : r_bin_size;
    assign cap    = (r_cap == '0) ? 17'd1 :
                    ((r_cap > 17'(MEM_DEPTH)) ? 17'(MEM_DEPTH) : r_cap);
    assign bin    = (r_bin_q > 16'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1) : r_bin_q[BIN_W-1:0];
    assign seed   = !r_last_valid || (bin != r_last_bin);
    assign div_t  = {r_bin_off, r_bin_q[15]};
    assign div_ge = div_t >= {1'b0, bs};
    assign idx_inc = {1'b0, r_idx} + 17'd1;
    assign gain_up = {1'b0, r_gain} + {1'b0, step};

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_frozen     = r_frozen;
        n_active     = r_active;
        n_stop       = r_stop;
        n_gain       = r_gain;
        n_last_valid = r_last_valid;
        n_last_bin   = r_last_bin;
        n_bin_q      = r_bin_q;
        n_bin_off    = r_bin_off;
        n_stale      = r_stale;
        n_div_cnt    = r_div_cnt;
        n_ld         = r_ld;
        n_wrote      = r_wrote;
        clr          = 1'b0;
        done         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_wrote = 1'b0;
                    n_ld    = 1'b0;
                    n_state = S_OUT;
                    case (i_kind)
                        KIND_AUDIO: begin
                            if (r_active) begin
                                n_wrote = 1'b1;
                                if (r_stale) begin
                                    n_state   = S_DIV;
                                    n_bin_q   = r_idx;
                                    n_bin_off = '0;
                                    n_div_cnt = '0;
                                end else begin
                                    n_state = S_RD;
                                end
                            end
                        end
                        KIND_TOGGLE: begin
                            if (!r_active && r_frozen != '0 && !r_od_en) begin
                                n_active = r_active;
                            end else if (!r_active) begin
                                n_active     = 1'b1;
                                n_idx        = '0;
                                n_bin_q      = '0;
                                n_bin_off    = '0;
                                n_stale      = 1'b0;
                                n_last_valid = 1'b0;
                                if (r_frozen == '0) begin
                                    n_gain = UNITY;
                                end else begin
                                    n_gain = (step != '0) ? 16'd0 : UNITY;
                                    n_stop = 1'b0;
                                    if (r_decay) begin
                                        n_ld    = 1'b1;
                                        n_state = S_RD;
                                    end
                                end
                            end else if (r_frozen == '0) begin
                                n_active = 1'b0;
                                n_frozen = {1'b0, r_idx};
                            end else if (step != '0) begin
                                n_stop = !r_stop;
                            end else begin
                                n_active = 1'b0;
                            end
                        end
                        KIND_CLEAR: begin
                            clr          = 1'b1;
                            n_frozen     = '0;
                            n_idx        = '0;
                            n_bin_q      = '0;
                            n_bin_off    = '0;
                            n_stale      = 1'b0;
                            n_active     = 1'b0;
                            n_stop       = 1'b0;
                            n_gain       = UNITY;
                            n_last_valid = 1'b0;
                        end
                        default: begin
                            n_wrote = 1'b0;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_bin_off = div_ge ? 17'(div_t - {1'b0, bs}) : div_t[16:0];
                n_bin_q   = {r_bin_q[14:0], div_ge};
                n_div_cnt = r_div_cnt + 4'd1;
                if (r_div_cnt == 4'd15) begin
                    n_stale = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_ld) begin
                    n_state = S_LD;
                end else if (r_frozen == '0) begin
                    n_state = S_WR;
                end else begin
                    n_state = S_M1;
                end
            end
            S_LD: n_state = S_OUT;
            S_M1: n_state = S_M2;
            S_M2: n_state = S_M3;
            S_M3: n_state = S_WR;
            S_WR: begin
                n_state      = S_OUT;
                n_last_bin   = bin;
                n_last_valid = 1'b1;
                if ({1'b0, r_bin_off} + 18'd1 >= {1'b0, bs}) begin
                    n_bin_off = '0;
                    n_bin_q   = r_bin_q + 16'd1;
                end else begin
                    n_bin_off = r_bin_off + 17'd1;
                end
                n_idx = idx_inc[ADDR_W-1:0];
                if (r_frozen == '0) begin
                    if (idx_inc >= cap) begin
                        n_frozen  = cap;
                        n_active  = 1'b0;
                        n_idx     = '0;
                        n_bin_q   = '0;
                        n_bin_off = '0;
                    end
                end else begin
                    if (idx_inc >= r_frozen) begin
                        n_idx     = '0;
                        n_bin_q   = '0;
                        n_bin_off = '0;
                    end
                    if (r_stop) begin
                        if (step >= r_gain) begin
                            n_gain   = '0;
                            n_stop   = 1'b0;
                            n_active = 1'b0;
                        end else begin
                            n_gain = r_gain - step;
                        end
                    end else if (r_gain < UNITY) begin
                        n_gain = (gain_up > {1'b0, UNITY}) ? UNITY : gain_up[15:0];
                    end
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_valid && i_cfg_index == CFG_BIN_SIZE) begin
            n_stale = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_frozen     <= '0;
            r_active     <= 1'b0;
            r_stop       <= 1'b0;
            r_gain       <= UNITY;
            r_last_valid <= 1'b0;
            r_last_bin   <= '0;
            r_bin_q      <= '0;
            r_bin_off    <= '0;
            r_stale      <= 1'b0;
            r_div_cnt    <= '0;
            r_ld         <= 1'b0;
            r_wrote      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_frozen     <= n_frozen;
            r_active     <= n_active;
            r_stop       <= n_stop;
            r_gain       <= n_gain;
            r_last_valid <= n_last_valid;
            r_last_bin   <= n_last_bin;
            r_bin_q      <= n_bin_q;
            r_bin_off    <= n_bin_off;
            r_stale      <= n_stale;
            r_div_cnt    <= n_div_cnt;
            r_ld         <= n_ld;
            r_wrote      <= n_wrote;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= 17'd65536;
            r_od_en    <= 1'b1;
            r_decay    <= 1'b0;
            r_fb       <= UNITY;
            r_coef     <= UNITY;
            r_step     <= '0;
            r_bin_size <= 17'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOOP_CAP:  r_cap      <= i_cfg_data;
                CFG_OVERDUB:   r_od_en    <= i_cfg_data[0];
                CFG_DECAY:     r_decay    <= i_cfg_data[0];
                CFG_FEEDBACK:  r_fb       <= i_cfg_data[15:0];
                CFG_DECAY_CF:  r_coef     <= i_cfg_data[15:0];
                CFG_GAIN_STEP: r_step     <= i_cfg_data[15:0];
                CFG_BIN_SIZE:  r_bin_size <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_ctl.rd    = (r_state == S_RD);
        o_ctl.ld    = (r_state == S_LD);
        o_ctl.m1    = (r_state == S_M1);
        o_ctl.m2    = (r_state == S_M2);
        o_ctl.m3    = (r_state == S_M3);
        o_ctl.wr    = (r_state == S_WR);
        o_ctl.clr   = clr;
        o_ctl.first = (r_frozen == '0);
        o_ctl.decay = r_decay;
        o_ctl.seed  = seed;
        o_ctl.addr  = r_idx;
        o_ctl.bin   = bin;
        o_ctl.coef  = clampq(r_coef);
        o_ctl.fb    = clampq(r_fb);
        o_ctl.gain  = r_gain;

        o_status.done         = done;
        o_status.wrote        = r_wrote;
        o_status.recording    = r_active;
        o_status.stop_pending = r_stop;
        o_status.loop_length  = r_frozen;
        o_status.write_pos    = 16'(r_idx);
    end

endmodule

`default_nettype wire

// ===== design/loop_record_overdub_engine_core.sv =====
// ----------------------------------------------------------------------------
// loop_record_overdub_engine_core
// Stereo loop recorder with overdub, decay lowpass and per-bin peaks.
// ----------------------------------------------------------------------------
// Sequence: a toggle, clear or idle sample goes straight to the result register;
// a toggle that starts a decay-mode overdub reads and loads the decay state first,
// a first-pass sample reads then writes memory, and an overdub sample reads, runs
// 3 multiplies (M1, M2, M3) and writes; the bin divider runs first on the first
// sample after a bin_size write. A new item is taken only once the last result has
// gone to the output register, so items are paced by these steps and back-pressure.
// Reset: synchronous; control and peak valid bits clear, sample memory kept.
`default_nettype none

module loop_record_overdub_engine_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [31:0]  i_s_axis_tdata,   // sample_left[15:0], sample_right[31:16]
    input  wire logic [1:0]   i_s_axis_tuser,   // kind[1:0]
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [71:0]       o_m_axis_tdata,   // recording[0], stop_pending[1],
                                                // loop_length[18:2], write_position[34:19],
                                                // stored_left[50:35], stored_right[66:51]
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [16:0]  i_cfg_data
);
    import lroe_pkg::*;

    t_lane_ctl ctl;
    t_status   status;

    logic signed [SAMPLE_W-1:0] r_in_l, r_in_r;
    logic signed [SAMPLE_W-1:0] stored_l, stored_r;
    logic        r_out_valid;
    logic [71:0] r_out_data;
    logic        out_free;
    logic        in_accept;

    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    lroe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_out_free  (out_free),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctl       (ctl),
        .o_status    (status)
    );

    lroe_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_sample (r_in_l),
        .o_stored (stored_l)
    );

    lroe_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_sample (r_in_r),
        .o_stored (stored_r)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_l <= i_s_axis_tdata[15:0];
            r_in_r <= i_s_axis_tdata[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (status.done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.done) begin
            r_out_data <= {5'd0,
                           status.wrote ? stored_r : 16'sd0,
                           status.wrote ? stored_l : 16'sd0,
                           status.write_pos,
                           status.loop_length,
                           status.stop_pending,
                           status.recording};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
